FILE: rtl/bdsr_pkg.sv
// Shared types and constants of the bus decoder with shared RAM window.
package bdsr_pkg;

  localparam int ADDR_W      = 24;
  localparam int MAP_W       = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int MAP_IDX_W   = 3;
  localparam int BANK_AW     = 12;

  localparam logic [ADDR_W-1:0] ADDR_BUSREQ = 24'hA11100;
  localparam logic [ADDR_W-1:0] ADDR_RESET  = 24'hA11200;
  localparam logic [ADDR_W-1:0] WIN_LO      = 24'hA00000;
  localparam logic [ADDR_W-1:0] WIN_HI      = 24'hA0FFFF;
  localparam logic [ADDR_W-1:0] RAM_HI      = 24'hA01FFF;
  localparam logic [MAP_W-1:0]  MAP_RESET   = 48'hFFFFFF000000;

  localparam logic [15:0] BYTE_OPEN = 16'h00FF;
  localparam logic [15:0] WORD_OPEN = 16'hFFFF;
  localparam logic [15:0] BYTE_FLAG = 16'h0001;
  localparam logic [15:0] WORD_FLAG = 16'h0100;

  typedef enum logic [2:0] {
    OP_RD_BYTE = 3'd0,
    OP_WR_BYTE = 3'd1,
    OP_RD_WORD = 3'd2,
    OP_WR_WORD = 3'd3,
    OP_RD_LONG = 3'd4,
    OP_WR_LONG = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    OC_LOCAL_READ  = 2'd0,
    OC_LOCAL_WRITE = 2'd1,
    OC_FORWARD     = 2'd2,
    OC_UNMAPPED    = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    CLS_BUSREQ = 2'd0,
    CLS_RESET  = 2'd1,
    CLS_RAM    = 2'd2,
    CLS_ROUTE  = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_RUN   = 2'd1,
    ST_READ  = 2'd2
  } back_state_t;

  // One word or byte sub-access after address decode.
  typedef struct packed {
    cls_t                 cls;
    logic                 wr;
    logic                 size;
    logic [ADDR_W-1:0]    addr;
    logic [15:0]          data;
    logic                 matched;
    logic [MAP_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    start;
    logic                 last;
  } sub_t;

endpackage

FILE: rtl/bdsr_if.sv
// Valid/ready channel interfaces for bus accesses and their results.
interface bdsr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] address;
  logic [31:0] write_value;

  modport source (output valid, operation, address, write_value, input ready);
  modport sink (input valid, operation, address, write_value, output ready);
endinterface

interface bdsr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [15:0] read_data;
  logic [1:0]  device_index;
  logic [23:0] device_offset;
  logic        forward_write;
  logic        forward_size;
  logic [15:0] forward_data;
  logic        last;

  modport source (output valid, outcome, read_data, device_index, device_offset,
                  forward_write, forward_size, forward_data, last, input ready);
  modport sink (input valid, outcome, read_data, device_index, device_offset,
                forward_write, forward_size, forward_data, last, output ready);
endinterface

FILE: rtl/bus_decoder_with_shared_ram_window.sv
// Top level of the bus decoder with shared RAM window.
//
// req carries one bus access per beat: operation, address (low 24 bits used)
// and write_value. rsp carries one result per beat; a longword access gives
// two beats, high word first, and last marks the final beat of an access.
// Operation codes 6 and 7 are taken and give no beat.
// The four map entries are written through cfg_we/cfg_index/cfg_data; the
// user does so only while the block is idle, which the block does not
// enforce. An index beyond the map is ignored. A shared RAM read passes the
// registered RAM port and the read state before its result beat.
// Throughput is one sub-access per cycle through the decode front end and
// the two-entry queue while the queue has room; a longword gives two
// sub-accesses, and a RAM read holds the back end in its read state.
// After reset the shared RAM is cleared one row of both byte banks per
// cycle, all 4096 rows, and req.ready stays low until that pass ends.
// When the receiver holds rsp.ready low, the result register keeps its beat,
// the queue fills and then the front end stops taking accesses.
module bus_decoder_with_shared_ram_window #(
  parameter int NUM_MAP_ENTRIES = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  bdsr_req_if.sink                         req,
  bdsr_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [bdsr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdsr_pkg::MAP_W-1:0]       cfg_data
);

  logic           push_valid;
  logic           push_ready;
  bdsr_pkg::sub_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  bdsr_pkg::sub_t pop_data;
  logic           clearing;

  bdsr_front #(
    .NUM_MAP_ENTRIES(NUM_MAP_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hold      (clearing),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  bdsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  bdsr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .head     (pop_data),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule

FILE: rtl/bdsr_front.sv
// Front end: accepts accesses, splits longwords and decodes each sub-access.
module bdsr_front #(
  parameter int NUM_MAP_ENTRIES = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  bdsr_req_if.sink                         req,
  input  logic                             cfg_we,
  input  logic [bdsr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdsr_pkg::MAP_W-1:0]       cfg_data,
  input  logic                             hold,
  output logic                             push_valid,
  input  logic                             push_ready,
  output bdsr_pkg::sub_t                   push_data
);

  logic [bdsr_pkg::MAP_W-1:0]  map_entry [NUM_MAP_ENTRIES];
  logic [2:0]                  cur_op;
  logic [bdsr_pkg::ADDR_W-1:0] cur_addr;
  logic [31:0]                 cur_wv;
  logic                        cur_valid;
  logic                        cur_half;

  logic                        op_ok;
  logic                        is_long;
  logic                        done;
  logic                        is_byte;
  logic                        wr;
  logic [bdsr_pkg::ADDR_W-1:0] a;
  logic [15:0]                 sub_data;
  logic [NUM_MAP_ENTRIES-1:0]  hit;
  logic                        matched;
  logic [bdsr_pkg::MAP_IDX_W-1:0] sel_idx;
  logic [bdsr_pkg::ADDR_W-1:0] sel_start;
  logic                        busreq_hit;
  logic                        reset_hit;
  logic                        win_hit;
  logic                        ramwin_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MAP_ENTRIES; i++) begin
        map_entry[i] <= bdsr_pkg::MAP_RESET;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_MAP_ENTRIES; i++) begin
        if (cfg_index == bdsr_pkg::CFG_INDEX_W'(i)) begin
          map_entry[i] <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    op_ok   = (cur_op == bdsr_pkg::OP_RD_BYTE) || (cur_op == bdsr_pkg::OP_WR_BYTE) ||
              (cur_op == bdsr_pkg::OP_RD_WORD) || (cur_op == bdsr_pkg::OP_WR_WORD) ||
              (cur_op == bdsr_pkg::OP_RD_LONG) || (cur_op == bdsr_pkg::OP_WR_LONG);
    is_long = (cur_op == bdsr_pkg::OP_RD_LONG) || (cur_op == bdsr_pkg::OP_WR_LONG);
    is_byte = (cur_op == bdsr_pkg::OP_RD_BYTE) || (cur_op == bdsr_pkg::OP_WR_BYTE);
    wr      = cur_op[0];
    // The second half of a longword sits two bytes up, wrapping in 24 bits.
    a       = cur_half ? (cur_addr + bdsr_pkg::ADDR_W'(2)) : cur_addr;
    if (is_byte) begin
      sub_data = {8'h00, cur_wv[7:0]};
    end else if (is_long && !cur_half) begin
      sub_data = cur_wv[31:16];
    end else begin
      sub_data = cur_wv[15:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_MAP_ENTRIES; i++) begin
      hit[i] = (a >= map_entry[i][47:24]) && (a <= map_entry[i][23:0]);
    end
    matched   = |hit;
    sel_idx   = '0;
    sel_start = '0;
    for (int i = NUM_MAP_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel_idx   = bdsr_pkg::MAP_IDX_W'(i);
        sel_start = map_entry[i][47:24];
      end
    end
  end

  always_comb begin
    busreq_hit = is_byte ? (a[23:1] == bdsr_pkg::ADDR_BUSREQ[23:1])
                         : (a == bdsr_pkg::ADDR_BUSREQ);
    reset_hit  = is_byte ? (a[23:1] == bdsr_pkg::ADDR_RESET[23:1])
                         : (a == bdsr_pkg::ADDR_RESET);
    win_hit    = (a >= bdsr_pkg::WIN_LO) && (a <= bdsr_pkg::WIN_HI);
    ramwin_hit = (a >= bdsr_pkg::WIN_LO) && (a <= bdsr_pkg::RAM_HI);

    push_data.wr      = wr;
    push_data.size    = !is_byte;
    push_data.addr    = a;
    push_data.data    = sub_data;
    push_data.matched = matched;
    push_data.idx     = sel_idx;
    push_data.start   = sel_start;
    push_data.last    = !is_long || cur_half;
    // Word reads see only the RAM part of the window; the rest is routed.
    if (busreq_hit) begin
      push_data.cls = bdsr_pkg::CLS_BUSREQ;
    end else if (reset_hit) begin
      push_data.cls = bdsr_pkg::CLS_RESET;
    end else if ((is_byte || wr) ? win_hit : ramwin_hit) begin
      push_data.cls = bdsr_pkg::CLS_RAM;
    end else begin
      push_data.cls = bdsr_pkg::CLS_ROUTE;
    end
  end

  assign push_valid = cur_valid && op_ok;
  assign done       = cur_valid && (!op_ok || (push_ready && (!is_long || cur_half)));
  assign req.ready  = !hold && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_half  <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        cur_valid <= 1'b1;
        cur_half  <= 1'b0;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (push_valid && push_ready) begin
        cur_half <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cur_op   <= req.operation;
      cur_addr <= req.address[bdsr_pkg::ADDR_W-1:0];
      cur_wv   <= req.write_value;
    end
  end

endmodule

FILE: rtl/bdsr_queue.sv
// Two-entry queue of decoded sub-accesses between front and back end.
module bdsr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bdsr_pkg::sub_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bdsr_pkg::sub_t pop_data
);

  bdsr_pkg::sub_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/bdsr_back.sv
// Back end: control flags, the banked shared RAM and the result register.
module bdsr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  bdsr_pkg::sub_t head,
  output logic           clearing,
  bdsr_rsp_if.source     rsp
);

  typedef struct packed {
    bdsr_pkg::outcome_t outcome;
    logic [15:0]        read_data;
    logic [1:0]         device_index;
    logic [23:0]        device_offset;
    logic               forward_write;
    logic               forward_size;
    logic [15:0]        forward_data;
    logic               last;
  } result_t;

  bdsr_pkg::back_state_t state;
  bdsr_pkg::back_state_t state_next;

  logic [7:0] even_mem [2**bdsr_pkg::BANK_AW];
  logic [7:0] odd_mem  [2**bdsr_pkg::BANK_AW];
  logic [7:0] even_q;
  logic [7:0] odd_q;

  logic [bdsr_pkg::BANK_AW-1:0] clr_cnt;
  logic                         bus_requested;
  logic                         reset_held;
  logic                         out_valid;
  result_t                      out_reg;
  bdsr_pkg::sub_t               pend;

  logic                         granted;
  logic                         slot_free;
  logic                         in_ram;
  logic                         need_read;
  logic                         pop;
  logic                         load;
  result_t                      res;
  logic                         even_we;
  logic                         odd_we;
  logic                         mem_re;
  logic [bdsr_pkg::BANK_AW-1:0] even_addr;
  logic [bdsr_pkg::BANK_AW-1:0] odd_addr;
  logic [7:0]                   even_wd;
  logic [7:0]                   odd_wd;
  logic [bdsr_pkg::BANK_AW-1:0] row;
  logic                         br_we;
  logic                         rh_we;
  logic                         flag_bit;

  assign granted   = bus_requested && !reset_held;
  assign slot_free = !out_valid || rsp.ready;
  assign in_ram    = (head.addr <= bdsr_pkg::RAM_HI);
  assign need_read = (head.cls == bdsr_pkg::CLS_RAM) && !head.wr && bus_requested &&
                     (head.size || in_ram);
  assign row       = head.addr[bdsr_pkg::BANK_AW:1];
  assign flag_bit  = head.size ? head.data[8] : head.data[0];

  always_comb begin
    state_next = state;
    unique case (state)
      bdsr_pkg::ST_CLEAR: begin
        if (&clr_cnt) begin
          state_next = bdsr_pkg::ST_RUN;
        end
      end
      bdsr_pkg::ST_RUN: begin
        if (pop_valid && slot_free && need_read) begin
          state_next = bdsr_pkg::ST_READ;
        end
      end
      bdsr_pkg::ST_READ: begin
        if (slot_free) begin
          state_next = bdsr_pkg::ST_RUN;
        end
      end
      default: state_next = bdsr_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    load      = 1'b0;
    clearing  = 1'b0;
    res       = '0;
    even_we   = 1'b0;
    odd_we    = 1'b0;
    mem_re    = 1'b0;
    br_we     = 1'b0;
    rh_we     = 1'b0;
    even_addr = row;
    odd_addr  = row;
    even_wd   = 8'h00;
    odd_wd    = 8'h00;
    res.last  = head.last;
    unique case (state)
      bdsr_pkg::ST_CLEAR: begin
        clearing  = 1'b1;
        even_we   = 1'b1;
        odd_we    = 1'b1;
        even_addr = clr_cnt;
        odd_addr  = clr_cnt;
      end
      bdsr_pkg::ST_RUN: begin
        pop  = pop_valid && slot_free;
        load = pop && !need_read;
        // An odd word start puts its low byte in the next even row.
        if (head.size && head.addr[0]) begin
          even_addr = row + bdsr_pkg::BANK_AW'(1);
        end
        unique case (head.cls)
          bdsr_pkg::CLS_BUSREQ: begin
            if (head.wr) begin
              br_we       = pop;
              res.outcome = bdsr_pkg::OC_LOCAL_WRITE;
            end else begin
              res.outcome   = bdsr_pkg::OC_LOCAL_READ;
              res.read_data = granted ? 16'h0000
                            : (head.size ? bdsr_pkg::WORD_FLAG : bdsr_pkg::BYTE_FLAG);
            end
          end
          bdsr_pkg::CLS_RESET: begin
            if (head.wr) begin
              rh_we       = pop;
              res.outcome = bdsr_pkg::OC_LOCAL_WRITE;
            end else begin
              res.outcome   = bdsr_pkg::OC_LOCAL_READ;
              res.read_data = reset_held ? 16'h0000
                            : (head.size ? bdsr_pkg::WORD_FLAG : bdsr_pkg::BYTE_FLAG);
            end
          end
          bdsr_pkg::CLS_RAM: begin
            if (head.wr) begin
              res.outcome = bdsr_pkg::OC_LOCAL_WRITE;
              if (pop && granted && in_ram) begin
                if (head.size) begin
                  even_we = 1'b1;
                  odd_we  = 1'b1;
                  even_wd = head.addr[0] ? head.data[7:0] : head.data[15:8];
                  odd_wd  = head.addr[0] ? head.data[15:8] : head.data[7:0];
                end else begin
                  even_we = !head.addr[0];
                  odd_we  = head.addr[0];
                  even_wd = head.data[7:0];
                  odd_wd  = head.data[7:0];
                end
              end
            end else begin
              res.outcome = bdsr_pkg::OC_LOCAL_READ;
              mem_re      = pop && need_read;
              if (!bus_requested) begin
                res.read_data = head.size ? bdsr_pkg::WORD_OPEN : bdsr_pkg::BYTE_OPEN;
              end
            end
          end
          bdsr_pkg::CLS_ROUTE: begin
            if (head.matched) begin
              res.outcome       = bdsr_pkg::OC_FORWARD;
              res.device_index  = head.idx[1:0];
              res.device_offset = head.addr - head.start;
              res.forward_write = head.wr;
              res.forward_size  = head.size;
              res.forward_data  = head.wr ? head.data : 16'h0000;
            end else begin
              res.outcome   = bdsr_pkg::OC_UNMAPPED;
              res.read_data = head.wr ? 16'h0000
                            : (head.size ? bdsr_pkg::WORD_OPEN : bdsr_pkg::BYTE_OPEN);
            end
          end
          default: res.outcome = bdsr_pkg::OC_UNMAPPED;
        endcase
      end
      bdsr_pkg::ST_READ: begin
        load        = slot_free;
        res.outcome = bdsr_pkg::OC_LOCAL_READ;
        res.last    = pend.last;
        if (!pend.size) begin
          res.read_data = {8'h00, pend.addr[0] ? odd_q : even_q};
        end else if (pend.addr[0]) begin
          res.read_data = {odd_q, even_q};
        end else begin
          res.read_data = {even_q, odd_q};
        end
      end
      default: clearing = 1'b0;
    endcase
  end

  assign pop_ready = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bdsr_pkg::ST_CLEAR;
      clr_cnt       <= '0;
      bus_requested <= 1'b0;
      reset_held    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bdsr_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + bdsr_pkg::BANK_AW'(1);
      end
      if (br_we) begin
        bus_requested <= flag_bit;
      end
      if (rh_we) begin
        reset_held <= !flag_bit;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= res;
    end
    if (mem_re) begin
      pend <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (even_we) begin
      even_mem[even_addr] <= even_wd;
    end
    if (mem_re) begin
      even_q <= even_mem[even_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (odd_we) begin
      odd_mem[odd_addr] <= odd_wd;
    end
    if (mem_re) begin
      odd_q <= odd_mem[odd_addr];
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.outcome       = out_reg.outcome;
  assign rsp.read_data     = out_reg.read_data;
  assign rsp.device_index  = out_reg.device_index;
  assign rsp.device_offset = out_reg.device_offset;
  assign rsp.forward_write = out_reg.forward_write;
  assign rsp.forward_size  = out_reg.forward_size;
  assign rsp.forward_data  = out_reg.forward_data;
  assign rsp.last          = out_reg.last;

`ifndef SYNTHESIS
  // No result may appear while the RAM is still being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == bdsr_pkg::ST_CLEAR) |-> !out_valid)
    else $error("result present during RAM clear");

  // A pending RAM read delivers its beat as soon as the result slot is free.
  a_read_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == bdsr_pkg::ST_READ && slot_free) |=> (out_valid && state == bdsr_pkg::ST_RUN))
    else $error("RAM read result not delivered");

  // The bus request flag moves only on a popped write to its control address.
  a_busreq_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(bus_requested)) |->
      $past(pop && head.cls == bdsr_pkg::CLS_BUSREQ && head.wr))
    else $error("bus request flag changed without a control write");

  // Nothing leaves the queue while a RAM read is outstanding.
  a_no_pop_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == bdsr_pkg::ST_READ) |-> !pop_ready)
    else $error("queue popped during RAM read");
`endif

endmodule
